>>> hw/rtl/mwr_pkg.sv
`timescale 1ns / 1ps

package mwr_pkg;

   // default map side
   localparam int GRID_SIDE_DEF = 16;

   // wall codes
   localparam logic [1:0] W_UNKNOWN = 2'd0;
   localparam logic [1:0] W_OPEN    = 2'd1;
   localparam logic [1:0] W_WALL    = 2'd2;

   // side codes
   localparam logic [1:0] SIDE_UP    = 2'd0;
   localparam logic [1:0] SIDE_DOWN  = 2'd1;
   localparam logic [1:0] SIDE_LEFT  = 2'd2;
   localparam logic [1:0] SIDE_RIGHT = 2'd3;

   // item functions
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic       func;
      logic [3:0] cell_x;
      logic [3:0] cell_y;
      logic [1:0] wall_side;
      logic [1:0] wall_value;
   } req_type;

   typedef struct packed {
      logic       cell_reachable;
      logic [7:0] cell_walls;
      logic       goal_found;
      logic [3:0] goal_x;
      logic [3:0] goal_y;
      logic       maze_complete;
   } rsp_type;

   // broadcast command to every cell
   typedef struct packed {
      logic       wr_en;
      logic [3:0] cell_x;
      logic [3:0] cell_y;
      logic [1:0] wall_side;
      logic [1:0] wall_value;
      logic       flood_start;
      logic       flood_step;
   } mwr_cmd_type;

   // per-cell status back to the controller
   typedef struct packed {
      logic sel;
      logic diff;
      logic grow;
      logic bad;
      logic hit;
      logic reach;
   } mwr_stat_type;

endpackage

>>> hw/rtl/mwr_cell.sv
`timescale 1ns / 1ps

module mwr_cell #(
   parameter int GRID = mwr_pkg::GRID_SIDE_DEF,
   parameter int IX   = 0,
   parameter int IY   = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mwr_pkg::mwr_cmd_type cmd,
   input  logic [3:0]           push_in,
   input  logic                 diag_in,
   output logic [3:0]           push_out,
   output logic                 diag_out,
   output logic [7:0]           walls,
   output mwr_pkg::mwr_stat_type stat
);

   localparam logic [1:0] R_UP    = (IY == GRID - 1) ? mwr_pkg::W_WALL : mwr_pkg::W_UNKNOWN;
   localparam logic [1:0] R_DOWN  = (IY == 0) ? mwr_pkg::W_WALL : mwr_pkg::W_UNKNOWN;
   localparam logic [1:0] R_LEFT  = (IX == 0) ? mwr_pkg::W_WALL : mwr_pkg::W_UNKNOWN;
   localparam logic [1:0] R_RIGHT = (IX == GRID - 1) ? mwr_pkg::W_WALL : mwr_pkg::W_UNKNOWN;
   localparam logic [7:0] RESET_WALLS = {R_RIGHT, R_LEFT, R_DOWN, R_UP};
   localparam logic [3:0] HAS_N = {IX < GRID - 1, IX > 0, IY > 0, IY < GRID - 1};
   localparam logic       IS_START = (IX == 0) && (IY == 0);

   logic [7:0] walls_ff, walls_in;
   logic       reach_ff, reach_in;
   logic       addr, nb, hit_wr;
   logic [1:0] sel_side;
   logic [1:0] cur;
   int         cx, cy;

   // decode role of this cell in a wall write
   always_comb begin
      cx = int'(cmd.cell_x);
      cy = int'(cmd.cell_y);
      addr = (cx == IX) && (cy == IY);
      case (cmd.wall_side)
         mwr_pkg::SIDE_UP:    nb = (cx == IX) && (cy + 1 == IY);
         mwr_pkg::SIDE_DOWN:  nb = (cx == IX) && (cy == IY + 1);
         mwr_pkg::SIDE_LEFT:  nb = (cx == IX + 1) && (cy == IY);
         mwr_pkg::SIDE_RIGHT: nb = (cx + 1 == IX) && (cy == IY);
         default:             nb = 1'b0;
      endcase
      sel_side = addr ? cmd.wall_side : (cmd.wall_side ^ 2'd1);
      hit_wr   = cmd.wr_en && (addr || nb);
      cur      = walls_ff[{sel_side, 1'b0} +: 2];
   end

   // update walls and reach
   always_comb begin
      walls_in = walls_ff;
      if (hit_wr) begin
         walls_in[{sel_side, 1'b0} +: 2] = cmd.wall_value;
      end
      reach_in = reach_ff;
      if (cmd.flood_start) begin
         reach_in = IS_START;
      end else if (cmd.flood_step) begin
         reach_in = reach_ff | (|push_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walls_ff <= RESET_WALLS;
         reach_ff <= 1'b0;
      end else begin
         walls_ff <= walls_in;
         reach_ff <= reach_in;
      end
   end

   // hand reach and goal corner flags to neighbors
   always_comb begin
      for (int s = 0; s < 4; s++) begin
         push_out[s] = reach_ff && HAS_N[s] && (walls_ff[2*s +: 2] == mwr_pkg::W_OPEN);
      end
      diag_out = (walls_ff[3:2] == mwr_pkg::W_OPEN) && (walls_ff[5:4] == mwr_pkg::W_OPEN);
      walls    = walls_ff;
      stat.sel   = addr;
      stat.diff  = hit_wr && (cur != cmd.wall_value);
      stat.grow  = cmd.flood_step && !reach_ff && (|push_in);
      stat.bad   = reach_ff && ((walls_ff[1:0] == mwr_pkg::W_UNKNOWN) ||
                                (walls_ff[3:2] == mwr_pkg::W_UNKNOWN) ||
                                (walls_ff[5:4] == mwr_pkg::W_UNKNOWN) ||
                                (walls_ff[7:6] == mwr_pkg::W_UNKNOWN));
      stat.hit   = (walls_ff[1:0] == mwr_pkg::W_OPEN) &&
                   (walls_ff[7:6] == mwr_pkg::W_OPEN) && diag_in;
      stat.reach = reach_ff;
   end

endmodule

>>> hw/rtl/maze_wall_map_reachability.sv
`timescale 1ns / 1ps

// Maze wall map with reachability flood and goal search.
// Input channel req_*: one item per transfer, either a wall write (func 0)
// or a cell query (func 1). req_stall stays high while an item is in work;
// one item is handled at a time.
// Result channel rsp_*: exactly one result per item, held in an output
// register until the receiver takes it with rsp_stall low. A new item may
// be accepted while that result still waits.
// Each item runs through apply (write the wall and restart the flood),
// flood (one wavefront step per cycle out from cell (0,0) through open
// sides, until no cell grows), then, while no goal is held, a goal scan,
// one lower-left cell a cycle up to the first hit, and last done, which
// forms the result. The block takes no new item until it is through with
// the last one; the flood steps of the cell array and the serial goal
// scan set the rate.
// Reset (synchronous) puts wall on every border side, unknown elsewhere,
// clears reach and the held goal; the block takes an item on the next cycle.
// If the receiver stalls, the finished result holds and the block stops
// before it would overwrite it.

module maze_wall_map_reachability #(
   parameter int GRID_SIDE = mwr_pkg::GRID_SIDE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mwr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mwr_pkg::rsp_type rsp_data
);

   localparam int CELLS = GRID_SIDE * GRID_SIDE;
   localparam int CW    = $clog2(GRID_SIDE);
   localparam int AW    = $clog2(CELLS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_APPLY = 3'd1;
   localparam logic [2:0] S_FLOOD = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]       state_ff, state_in;
   mwr_pkg::req_type item_ff, item_in;
   logic             goal_valid_ff, goal_valid_in;
   logic [CW-1:0]    goal_col_ff, goal_col_in;
   logic [CW-1:0]    goal_row_ff, goal_row_in;
   logic [CW-1:0]    scan_x_ff, scan_x_in;
   logic [CW-1:0]    scan_y_ff, scan_y_in;
   mwr_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   mwr_pkg::mwr_cmd_type  cmd;
   logic [3:0]            push_out [CELLS];
   logic [3:0]            push_in  [CELLS];
   logic                  diag_out [CELLS];
   logic                  diag_in  [CELLS];
   logic [7:0]            walls    [CELLS];
   mwr_pkg::mwr_stat_type stat     [CELLS];

   logic [CELLS-1:0] hit_vec;
   logic             any_diff, any_grow, any_bad, sel_reach;
   logic [7:0]       sel_walls;
   logic             on_map, req_xfer, load_rsp, goal_near;
   logic [AW-1:0]    scan_id;
   int               dx, dy;

   // cell array
   for (genvar gx = 0; gx < GRID_SIDE; gx++) begin : g_col
      for (genvar gy = 0; gy < GRID_SIDE; gy++) begin : g_row
         localparam int ID = gx * GRID_SIDE + gy;

         if (gy < GRID_SIDE - 1) begin : g_up
            assign push_in[ID][0] = push_out[ID + 1][1];
         end else begin : g_up_edge
            assign push_in[ID][0] = 1'b0;
         end
         if (gy > 0) begin : g_dn
            assign push_in[ID][1] = push_out[ID - 1][0];
         end else begin : g_dn_edge
            assign push_in[ID][1] = 1'b0;
         end
         if (gx > 0) begin : g_lt
            assign push_in[ID][2] = push_out[ID - GRID_SIDE][3];
         end else begin : g_lt_edge
            assign push_in[ID][2] = 1'b0;
         end
         if (gx < GRID_SIDE - 1) begin : g_rt
            assign push_in[ID][3] = push_out[ID + GRID_SIDE][2];
         end else begin : g_rt_edge
            assign push_in[ID][3] = 1'b0;
         end
         if (gx < GRID_SIDE - 1 && gy < GRID_SIDE - 1) begin : g_dg
            assign diag_in[ID] = diag_out[ID + GRID_SIDE + 1];
         end else begin : g_dg_edge
            assign diag_in[ID] = 1'b0;
         end

         mwr_cell #(
            .GRID (GRID_SIDE),
            .IX   (gx),
            .IY   (gy)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .cmd      (cmd),
            .push_in  (push_in[ID]),
            .diag_in  (diag_in[ID]),
            .push_out (push_out[ID]),
            .diag_out (diag_out[ID]),
            .walls    (walls[ID]),
            .stat     (stat[ID])
         );
      end
   end

   // gather cell status
   always_comb begin
      any_diff  = 1'b0;
      any_grow  = 1'b0;
      any_bad   = 1'b0;
      sel_reach = 1'b0;
      sel_walls = 8'd0;
      for (int i = 0; i < CELLS; i++) begin
         any_diff  = any_diff | stat[i].diff;
         any_grow  = any_grow | stat[i].grow;
         any_bad   = any_bad | stat[i].bad;
         sel_reach = sel_reach | (stat[i].sel & stat[i].reach);
         sel_walls = sel_walls | (walls[i] & {8{stat[i].sel}});
         hit_vec[i] = stat[i].hit;
      end
   end

   // broadcast command
   always_comb begin
      on_map = (int'(item_ff.cell_x) < GRID_SIDE) && (int'(item_ff.cell_y) < GRID_SIDE);
      cmd.wr_en       = (state_ff == S_APPLY) && (item_ff.func == mwr_pkg::FUNC_WRITE) &&
                        on_map;
      cmd.cell_x      = item_ff.cell_x;
      cmd.cell_y      = item_ff.cell_y;
      cmd.wall_side   = item_ff.wall_side;
      cmd.wall_value  = item_ff.wall_value;
      cmd.flood_start = (state_ff == S_APPLY);
      cmd.flood_step  = (state_ff == S_FLOOD);
   end

   // sequence one item
   always_comb begin
      req_xfer      = req_valid && !req_stall;
      load_rsp      = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
      state_in      = state_ff;
      item_in       = item_ff;
      goal_valid_in = goal_valid_ff;
      goal_col_in   = goal_col_ff;
      goal_row_in   = goal_row_ff;
      scan_x_in     = scan_x_ff;
      scan_y_in     = scan_y_ff;
      scan_id       = AW'(int'(scan_x_ff) * GRID_SIDE + int'(scan_y_ff));
      dx            = int'(goal_col_ff) - int'(item_ff.cell_x);
      dy            = int'(goal_row_ff) - int'(item_ff.cell_y);
      goal_near     = (dx >= -2) && (dx <= 1) && (dy >= -2) && (dy <= 1);
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               item_in = req_data;
               if (req_data.wall_value == 2'd3) begin
                  item_in.wall_value = mwr_pkg::W_WALL;
               end
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            // drop a nearby goal when a wall goes back to unknown
            if (cmd.wr_en && any_diff && (item_ff.wall_value == mwr_pkg::W_UNKNOWN) &&
                goal_valid_ff && goal_near) begin
               goal_valid_in = 1'b0;
               goal_col_in   = '0;
               goal_row_in   = '0;
            end
            state_in = S_FLOOD;
         end
         S_FLOOD: begin
            if (!any_grow) begin
               scan_x_in = '0;
               scan_y_in = '0;
               state_in  = goal_valid_ff ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit_vec[scan_id]) begin
               goal_valid_in = 1'b1;
               goal_col_in   = scan_x_ff;
               goal_row_in   = scan_y_ff;
               state_in      = S_DONE;
            end else if (int'(scan_y_ff) == GRID_SIDE - 1) begin
               scan_y_in = '0;
               if (int'(scan_x_ff) == GRID_SIDE - 1) begin
                  state_in = S_DONE;
               end else begin
                  scan_x_in = scan_x_ff + 1'b1;
               end
            end else begin
               scan_y_in = scan_y_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // form the result
   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_in.cell_reachable = sel_reach;
         rsp_in.cell_walls     = sel_walls;
         rsp_in.goal_found     = goal_valid_ff;
         rsp_in.goal_x         = 4'(goal_col_ff);
         rsp_in.goal_y         = 4'(goal_row_ff);
         rsp_in.maze_complete  = !any_bad;
         rsp_valid_in          = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         goal_valid_ff <= 1'b0;
         goal_col_ff   <= '0;
         goal_row_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         goal_valid_ff <= goal_valid_in;
         goal_col_ff   <= goal_col_in;
         goal_row_ff   <= goal_row_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      scan_x_ff <= scan_x_in;
      scan_y_ff <= scan_y_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result loaded outside the done state");

   a_start_reached: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLOOD) |-> stat[0].reach)
      else $error("start cell not reached during flood");

   a_goal_in_range: assert property (@(posedge clock) disable iff (reset)
      goal_valid_ff |-> (int'(goal_col_ff) < GRID_SIDE - 1) &&
                        (int'(goal_row_ff) < GRID_SIDE - 1))
      else $error("goal corner off the scan range");

   a_goal_cleared: assert property (@(posedge clock) disable iff (reset)
      !goal_valid_ff |-> (goal_col_ff == '0) && (goal_row_ff == '0))
      else $error("stale goal coordinates");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

// Tracks the expected maze state and the results still owed by the block.
class maze_scoreboard;
   logic [7:0]       walls [256];
   bit               reach [256];
   bit               goal_ok;
   logic [3:0]       goal_col;
   logic [3:0]       goal_row;
   mwr_pkg::rsp_type owed [$];
   int               errors;

   function new();
      clear();
   endfunction

   function void clear();
      for (int x = 0; x < 16; x++) begin
         for (int y = 0; y < 16; y++) begin
            walls[x*16+y] = 8'h00;
            if (y == 15) walls[x*16+y][1:0] = mwr_pkg::W_WALL;
            if (y == 0)  walls[x*16+y][3:2] = mwr_pkg::W_WALL;
            if (x == 0)  walls[x*16+y][5:4] = mwr_pkg::W_WALL;
            if (x == 15) walls[x*16+y][7:6] = mwr_pkg::W_WALL;
         end
      end
      goal_ok  = 0;
      goal_col = '0;
      goal_row = '0;
      owed.delete();
      errors = 0;
   endfunction

   function logic [1:0] side_of(int idx, logic [1:0] s);
      return walls[idx][2*s +: 2];
   endfunction

   // Neighbor index across a side, -1 at the map edge.
   function int across(int x, int y, logic [1:0] s);
      case (s)
         mwr_pkg::SIDE_UP:    return (y == 15) ? -1 : x*16 + y + 1;
         mwr_pkg::SIDE_DOWN:  return (y == 0)  ? -1 : x*16 + y - 1;
         mwr_pkg::SIDE_LEFT:  return (x == 0)  ? -1 : (x-1)*16 + y;
         default:             return (x == 15) ? -1 : (x+1)*16 + y;
      endcase
   endfunction

   function void put_wall(int x, int y, logic [1:0] s, logic [1:0] v);
      int idx;
      int nb;
      int dx;
      int dy;
      idx = x*16 + y;
      nb  = across(x, y, s);
      if (side_of(idx, s) == v && (nb < 0 || side_of(nb, s ^ 2'd1) == v)) return;
      walls[idx][2*s +: 2] = v;
      if (nb >= 0) walls[nb][2*(s ^ 2'd1) +: 2] = v;
      if (v == mwr_pkg::W_UNKNOWN && goal_ok) begin
         dx = int'(goal_col) - x;
         dy = int'(goal_row) - y;
         if (dx >= -2 && dx <= 1 && dy >= -2 && dy <= 1) begin
            goal_ok  = 0;
            goal_col = '0;
            goal_row = '0;
         end
      end
   endfunction

   function void flood_reach();
      int work [$];
      int cur;
      int nb;
      foreach (reach[i]) reach[i] = 0;
      reach[0] = 1;
      work.push_back(0);
      while (work.size() > 0) begin
         cur = work.pop_front();
         for (int s = 0; s < 4; s++) begin
            nb = across(cur / 16, cur % 16, s[1:0]);
            if (nb >= 0 && side_of(cur, s[1:0]) == mwr_pkg::W_OPEN && !reach[nb]) begin
               reach[nb] = 1;
               work.push_back(nb);
            end
         end
      end
   endfunction

   function bit reach_known();
      for (int i = 0; i < 256; i++)
         if (reach[i])
            for (int s = 0; s < 4; s++)
               if (side_of(i, s[1:0]) == mwr_pkg::W_UNKNOWN) return 0;
      return 1;
   endfunction

   function void scan_goal();
      int bl;
      int ur;
      if (goal_ok) return;
      for (int x = 0; x < 15; x++) begin
         for (int y = 0; y < 15; y++) begin
            bl = x*16 + y;
            ur = (x+1)*16 + y + 1;
            if (side_of(bl, mwr_pkg::SIDE_UP) == mwr_pkg::W_OPEN &&
                side_of(bl, mwr_pkg::SIDE_RIGHT) == mwr_pkg::W_OPEN &&
                side_of(ur, mwr_pkg::SIDE_DOWN) == mwr_pkg::W_OPEN &&
                side_of(ur, mwr_pkg::SIDE_LEFT) == mwr_pkg::W_OPEN) begin
               goal_ok  = 1;
               goal_col = x[3:0];
               goal_row = y[3:0];
               return;
            end
         end
      end
   endfunction

   // Apply one accepted transfer and queue its result.
   function void note_req(mwr_pkg::req_type r);
      mwr_pkg::rsp_type e;
      logic [1:0]       v;
      int               idx;
      v = (r.wall_value == 2'd3) ? mwr_pkg::W_WALL : r.wall_value;
      if (r.func == mwr_pkg::FUNC_WRITE) put_wall(r.cell_x, r.cell_y, r.wall_side, v);
      flood_reach();
      scan_goal();
      idx = int'(r.cell_x) * 16 + int'(r.cell_y);
      e.cell_reachable = reach[idx];
      e.cell_walls     = walls[idx];
      e.goal_found     = goal_ok;
      e.goal_x         = goal_col;
      e.goal_y         = goal_row;
      e.maze_complete  = reach_known();
      owed.push_back(e);
   endfunction

   function void check_rsp(mwr_pkg::rsp_type a);
      mwr_pkg::rsp_type e;
      if (owed.size() == 0) begin
         $error("result with nothing owed: %h", a);
         errors++;
         return;
      end
      e = owed.pop_front();
      if (a.cell_reachable !== e.cell_reachable) begin
         $error("cell_reachable exp %0d got %0d", e.cell_reachable, a.cell_reachable);
         errors++;
      end
      if (a.cell_walls !== e.cell_walls) begin
         $error("cell_walls exp %h got %h", e.cell_walls, a.cell_walls);
         errors++;
      end
      if (a.goal_found !== e.goal_found) begin
         $error("goal_found exp %0d got %0d", e.goal_found, a.goal_found);
         errors++;
      end
      if (a.goal_x !== e.goal_x) begin
         $error("goal_x exp %0d got %0d", e.goal_x, a.goal_x);
         errors++;
      end
      if (a.goal_y !== e.goal_y) begin
         $error("goal_y exp %0d got %0d", e.goal_y, a.goal_y);
         errors++;
      end
      if (a.maze_complete !== e.maze_complete) begin
         $error("maze_complete exp %0d got %0d", e.maze_complete, a.maze_complete);
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam int CYCLE_LIMIT = 4000000;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_stall;
   mwr_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 0;
   mwr_pkg::rsp_type rsp_data;

   maze_scoreboard maze_sb = new();
   bit      long_hold = 0;
   int      cycle_count = 0;

   maze_wall_map_reachability u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Count cycles and give up at the limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Check each result transfer.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) maze_sb.check_rsp(rsp_data);
   end

   // Stall the result side on its own pattern, with one long hold.
   initial begin
      int mode;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (3000) @(negedge clock);
            long_hold = 0;
            rsp_stall <= 0;
         end else begin
            mode = (cycle_count / 5000) % 3;
            if (mode == 0) rsp_stall <= 0;
            else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
            else rsp_stall <= ($urandom_range(0, 1) == 0);
         end
      end
   end

   // Offer one item and hold it until it transfers.
   task automatic send_item(mwr_pkg::req_type r);
      req_valid <= 1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      maze_sb.note_req(r);
      @(negedge clock);
   endtask

   task automatic gap(int n);
      req_valid <= 0;
      repeat (n) @(negedge clock);
   endtask

   function automatic mwr_pkg::req_type make_req(logic f, int x, int y, int s, int v);
      mwr_pkg::req_type r;
      r.func       = f;
      r.cell_x     = x[3:0];
      r.cell_y     = y[3:0];
      r.wall_side  = s[1:0];
      r.wall_value = v[1:0];
      return r;
   endfunction

   // Open the inner sides of the 2x2 block whose lower-left cell is (x,y).
   task automatic open_block(int x, int y);
      send_item(make_req(mwr_pkg::FUNC_WRITE, x, y, mwr_pkg::SIDE_UP, mwr_pkg::W_OPEN));
      send_item(make_req(mwr_pkg::FUNC_WRITE, x, y, mwr_pkg::SIDE_RIGHT, mwr_pkg::W_OPEN));
      send_item(make_req(mwr_pkg::FUNC_WRITE, x + 1, y + 1, mwr_pkg::SIDE_DOWN,
                         mwr_pkg::W_OPEN));
      send_item(make_req(mwr_pkg::FUNC_WRITE, x + 1, y + 1, mwr_pkg::SIDE_LEFT,
                         mwr_pkg::W_OPEN));
   endtask

   initial begin
      int sent;
      int burst;
      mwr_pkg::req_type r;
      repeat (6) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: extremes, border writes, goal find and clear, value three.
      send_item(make_req(mwr_pkg::FUNC_QUERY, 0, 0, 0, 0));
      send_item(make_req(mwr_pkg::FUNC_QUERY, 15, 15, 3, 3));
      send_item(make_req(mwr_pkg::FUNC_WRITE, 0, 0, mwr_pkg::SIDE_LEFT, mwr_pkg::W_OPEN));
      send_item(make_req(mwr_pkg::FUNC_WRITE, 0, 0, mwr_pkg::SIDE_DOWN, mwr_pkg::W_WALL));
      send_item(make_req(mwr_pkg::FUNC_WRITE, 0, 0, mwr_pkg::SIDE_UP, mwr_pkg::W_WALL));
      send_item(make_req(mwr_pkg::FUNC_WRITE, 0, 0, mwr_pkg::SIDE_RIGHT, mwr_pkg::W_WALL));
      send_item(make_req(mwr_pkg::FUNC_WRITE, 0, 0, mwr_pkg::SIDE_LEFT, mwr_pkg::W_WALL));
      send_item(make_req(mwr_pkg::FUNC_QUERY, 0, 0, 0, 0));
      send_item(make_req(mwr_pkg::FUNC_WRITE, 15, 15, mwr_pkg::SIDE_UP, mwr_pkg::W_OPEN));
      send_item(make_req(mwr_pkg::FUNC_WRITE, 15, 15, mwr_pkg::SIDE_RIGHT, 3));
      send_item(make_req(mwr_pkg::FUNC_WRITE, 0, 0, mwr_pkg::SIDE_UP, mwr_pkg::W_OPEN));
      open_block(0, 1);
      open_block(14, 14);
      send_item(make_req(mwr_pkg::FUNC_WRITE, 2, 3, mwr_pkg::SIDE_LEFT, mwr_pkg::W_UNKNOWN));
      send_item(make_req(mwr_pkg::FUNC_WRITE, 0, 1, mwr_pkg::SIDE_UP, mwr_pkg::W_UNKNOWN));
      send_item(make_req(mwr_pkg::FUNC_WRITE, 0, 1, mwr_pkg::SIDE_UP, mwr_pkg::W_UNKNOWN));
      send_item(make_req(mwr_pkg::FUNC_QUERY, 14, 14, 0, 0));
      send_item(make_req(mwr_pkg::FUNC_WRITE, 7, 8, mwr_pkg::SIDE_DOWN, 3));

      // Random: half corridor building near the start, the rest noise and queries.
      sent = 25;
      while (sent < 1550) begin
         burst = $urandom_range(1, 20);
         repeat (burst) begin
            if (sent == 700) long_hold = 1;
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4:
                  r = make_req(mwr_pkg::FUNC_WRITE, $urandom_range(0, 5),
                               $urandom_range(0, 5), $urandom_range(0, 3),
                               ($urandom_range(0, 3) == 0) ?
                               $urandom_range(0, 3) : mwr_pkg::W_OPEN);
               5, 6:
                  r = make_req(mwr_pkg::FUNC_WRITE, $urandom_range(0, 15),
                               $urandom_range(0, 15), $urandom_range(0, 3),
                               $urandom_range(0, 3));
               7:
                  r = make_req(mwr_pkg::FUNC_WRITE, $urandom_range(0, 15),
                               $urandom_range(0, 15), $urandom_range(0, 3),
                               mwr_pkg::W_WALL);
               default:
                  r = make_req(mwr_pkg::FUNC_QUERY, $urandom_range(0, 15),
                               $urandom_range(0, 15), $urandom_range(0, 3),
                               $urandom_range(0, 3));
            endcase
            send_item(r);
            sent++;
         end
         if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 30));
      end
      req_valid <= 0;

      // Drain outstanding results, then let the block settle.
      while (maze_sb.owed.size() > 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (maze_sb.errors == 0 && maze_sb.owed.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

>>> files.f
hw/rtl/mwr_pkg.sv
hw/rtl/mwr_cell.sv
hw/rtl/maze_wall_map_reachability.sv
sim/tb_top.sv
